// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define VIDC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define VIDC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/vidc_pkg.sv =====
// types, constants and codes of the vertex id compaction block
`timescale 1ns / 1ps
`default_nettype none
package vidc_pkg;

  localparam int unsigned RAW_ID_SPACE = 65536;
  localparam int unsigned MAX_VERTICES = 65536;
  localparam int unsigned DEGREE_BITS  = 32;

  localparam int unsigned RAW_BITS = $clog2(RAW_ID_SPACE);
  localparam int unsigned VID_BITS = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_BITS = VID_BITS + 1;

  localparam logic [DEGREE_BITS-1:0] DEG_MAX = '1;

  // result kinds
  localparam logic [1:0] KIND_FWD  = 2'd0;
  localparam logic [1:0] KIND_REV  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_EDGE     = 2'd0,
    OP_READ     = 2'd1,
    OP_DROP     = 2'd2,
    OP_READ_ERR = 2'd3
  } op_e;

  typedef struct packed {
    logic        action;
    logic [31:0] src_raw_id;
    logic [31:0] dst_raw_id;
    logic [15:0] read_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] degree_value;
    logic [16:0] vertex_count;
    logic        error;
    logic        last;
  } result_t;

  // classified item as it waits between front and back
  typedef struct packed {
    op_e                 op;
    logic [RAW_BITS-1:0] src;
    logic [RAW_BITS-1:0] dst;
    logic                same;
    logic [VID_BITS-1:0] ridx;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } bk_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/vertex_id_compaction_degree_count.sv =====
// a good edge passes the queue, then the states idle, resolve and update, which registers its
// forward result; finish registers the reversed edge in the next cycle. a readout is registered
// in readout, a dropped edge or bad read index in idle. the back end finishes one item before it
// takes the next; its edge steps are split by the single write port of the id map and of the degree store.
// reset: async active low; a pass over every id map entry then clears the id map, busy high meanwhile.
// results appear for one cycle on strobe_o and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vertex_id_compaction_degree_count (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  vidc_pkg::item_t   item_i,
  output logic              strobe_o,
  output vidc_pkg::result_t result_o
);
  import vidc_pkg::*;

  bk_stat_t bk_stat;
  entry_t   push_entry;
  entry_t   head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  vidc_front u_front (
    .start     (start),
    .item_i    (item_i),
    .bk_stat_i (bk_stat),
    .q_full_i  (q_full),
    .busy      (busy),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  vidc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vidc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .head_i    (head),
    .pop_o     (pop),
    .stat_o    (bk_stat),
    .strobe_o  (strobe_o),
    .result_o  (result_o)
  );

  // a good forward edge is always followed by its reversed edge
  `VIDC_ASSERT_NXT(a_fwd_then_rev, clk_i, rst_ni, strobe_o && result_o.kind == KIND_FWD && !result_o.error, strobe_o && result_o.kind == KIND_REV)
  // a reversed edge never stands alone
  `VIDC_ASSERT_IMP(a_rev_after_fwd, clk_i, rst_ni, strobe_o && result_o.kind == KIND_REV, $past(strobe_o) && $past(result_o.kind) == KIND_FWD)
  // no item is taken while the id map is being cleared
  `VIDC_ASSERT_IMP(a_busy_clear, clk_i, rst_ni, bk_stat.clearing, busy)

endmodule
`default_nettype wire

// ===== rtl/core/vidc_front.sv =====
// front end: accepts items, checks ranges and sorts them into operations
`timescale 1ns / 1ps
`default_nettype none
module vidc_front (
  input  logic              start,
  input  vidc_pkg::item_t   item_i,
  input  vidc_pkg::bk_stat_t bk_stat_i,
  input  logic              q_full_i,
  output logic              busy,
  output logic              push_o,
  output vidc_pkg::entry_t  entry_o
);
  import vidc_pkg::*;

  logic src_oob;
  logic dst_oob;
  logic ridx_oob;

  assign busy   = q_full_i | bk_stat_i.clearing;
  assign push_o = start & ~busy;

  always_comb begin
    src_oob  = 33'(item_i.src_raw_id) >= 33'(RAW_ID_SPACE);
    dst_oob  = 33'(item_i.dst_raw_id) >= 33'(RAW_ID_SPACE);
    ridx_oob = 33'(item_i.read_index) >= 33'(MAX_VERTICES);

    entry_o.src  = item_i.src_raw_id[RAW_BITS-1:0];
    entry_o.dst  = item_i.dst_raw_id[RAW_BITS-1:0];
    entry_o.same = item_i.src_raw_id == item_i.dst_raw_id;
    entry_o.ridx = VID_BITS'(item_i.read_index);

    if (item_i.action) begin
      entry_o.op = ridx_oob ? OP_READ_ERR : OP_READ;
    end else begin
      entry_o.op = (src_oob | dst_oob) ? OP_DROP : OP_EDGE;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vidc_queue.sv =====
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module vidc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vidc_pkg::entry_t entry_i,
  input  logic             pop_i,
  output vidc_pkg::entry_t head_o,
  output logic             full_o,
  output logic             empty_o
);
  import vidc_pkg::*;

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign head_o  = slot_q[rd_ptr_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vidc_back.sv =====
// back end: id map, degree store and the edge sequencer
`timescale 1ns / 1ps
`default_nettype none
module vidc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  vidc_pkg::entry_t    head_i,
  output logic                pop_o,
  output vidc_pkg::bk_stat_t  stat_o,
  output logic                strobe_o,
  output vidc_pkg::result_t   result_o
);
  import vidc_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_RESOLVE = 6'b000100,
    ST_UPDATE  = 6'b001000,
    ST_FINISH  = 6'b010000,
    ST_READOUT = 6'b100000
  } state_e;

  // map entry: valid bit on top of the dense id
  logic [VID_BITS:0]      map_mem [RAW_ID_SPACE];
  logic [DEGREE_BITS-1:0] deg_mem [MAX_VERTICES];

  state_e                 st_q, st_d;
  logic [RAW_BITS-1:0]    clr_q, clr_d;
  logic [CNT_BITS-1:0]    next_q, next_d;
  entry_t                 cur_q, cur_d;
  logic [VID_BITS-1:0]    s_q, s_d;
  logic [VID_BITS-1:0]    d_q, d_d;
  logic                   s_old_q, s_old_d;
  logic                   d_old_q, d_old_d;
  logic                   new_dst_q, new_dst_d;
  logic                   rd_ok_q, rd_ok_d;
  logic                   strobe_q, strobe_d;
  result_t                res_q, res_d;

  logic [VID_BITS:0]      map_rd_a_q, map_rd_b_q;
  logic [DEGREE_BITS-1:0] deg_rd_a_q, deg_rd_b_q;

  logic                   map_we;
  logic [RAW_BITS-1:0]    map_waddr;
  logic [VID_BITS:0]      map_wdata;
  logic                   deg_we;
  logic [VID_BITS-1:0]    deg_waddr;
  logic [DEGREE_BITS-1:0] deg_wdata;
  logic [VID_BITS-1:0]    deg_raddr_a, deg_raddr_b;

  logic                   vs, vd;
  logic [1:0]             need;
  logic                   full;
  logic [VID_BITS-1:0]    s_id, d_id;
  logic [DEGREE_BITS-1:0] old_s, old_d;
  logic [DEGREE_BITS:0]   sum_s, sum_d;
  logic [DEGREE_BITS-1:0] new_s, new_d;
  logic [31:0]            deg_out;
  logic [16:0]            vcount;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    bswap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  assign pop_o           = (st_q == ST_IDLE) & ~q_empty_i;
  assign stat_o.clearing = st_q == ST_CLEAR;
  assign strobe_o        = strobe_q;
  assign result_o        = res_q;

  // id resolution from the registered map reads
  always_comb begin
    vs     = map_rd_a_q[VID_BITS];
    vd     = map_rd_b_q[VID_BITS];
    need   = {1'b0, ~vs} + {1'b0, ~cur_q.same & ~vd};
    full   = ({1'b0, next_q} + (CNT_BITS + 1)'(need)) > (CNT_BITS + 1)'(MAX_VERTICES);
    s_id   = vs ? map_rd_a_q[VID_BITS-1:0] : next_q[VID_BITS-1:0];
    if (cur_q.same) begin
      d_id = s_id;
    end else if (vd) begin
      d_id = map_rd_b_q[VID_BITS-1:0];
    end else begin
      d_id = next_q[VID_BITS-1:0] + {{(VID_BITS-1){1'b0}}, ~vs};
    end
  end

  // saturating degree updates, a self-loop adds two
  always_comb begin
    old_s = s_old_q ? deg_rd_a_q : '0;
    old_d = d_old_q ? deg_rd_b_q : '0;
    sum_s = {1'b0, old_s} + (DEGREE_BITS + 1)'(cur_q.same ? 2'd2 : 2'd1);
    sum_d = {1'b0, old_d} + (DEGREE_BITS + 1)'(1'b1);
    new_s = (sum_s > {1'b0, DEG_MAX}) ? DEG_MAX : sum_s[DEGREE_BITS-1:0];
    new_d = (sum_d > {1'b0, DEG_MAX}) ? DEG_MAX : sum_d[DEGREE_BITS-1:0];
    deg_out = (64'(deg_rd_a_q) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(deg_rd_a_q);
    vcount  = 17'(next_q);
  end

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    next_d      = next_q;
    cur_d       = cur_q;
    s_d         = s_q;
    d_d         = d_q;
    s_old_d     = s_old_q;
    d_old_d     = d_old_q;
    new_dst_d   = new_dst_q;
    rd_ok_d     = rd_ok_q;
    strobe_d    = 1'b0;
    res_d       = res_q;
    map_we      = 1'b0;
    map_waddr   = clr_q;
    map_wdata   = '0;
    deg_we      = 1'b0;
    deg_waddr   = s_q;
    deg_wdata   = new_s;
    deg_raddr_a = head_i.ridx;
    deg_raddr_b = d_id;

    case (st_q)
      ST_CLEAR: begin
        map_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (&clr_q) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          cur_d   = head_i;
          rd_ok_d = CNT_BITS'(head_i.ridx) < next_q;
          case (head_i.op)
            OP_EDGE: st_d = ST_RESOLVE;
            OP_READ: st_d = ST_READOUT;
            OP_DROP: begin
              strobe_d           = 1'b1;
              res_d              = '0;
              res_d.kind         = KIND_FWD;
              res_d.vertex_count = vcount;
              res_d.error        = 1'b1;
              res_d.last         = 1'b1;
            end
            OP_READ_ERR: begin
              strobe_d           = 1'b1;
              res_d              = '0;
              res_d.kind         = KIND_READ;
              res_d.vertex_count = vcount;
              res_d.error        = 1'b1;
              res_d.last         = 1'b1;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_RESOLVE: begin
        deg_raddr_a = s_id;
        if (full) begin
          strobe_d           = 1'b1;
          res_d              = '0;
          res_d.kind         = KIND_FWD;
          res_d.vertex_count = vcount;
          res_d.error        = 1'b1;
          res_d.last         = 1'b1;
          st_d               = ST_IDLE;
        end else begin
          next_d    = next_q + CNT_BITS'(need);
          s_d       = s_id;
          d_d       = d_id;
          s_old_d   = vs;
          d_old_d   = vd;
          new_dst_d = ~cur_q.same & ~vd;
          map_we    = ~vs;
          map_waddr = cur_q.src;
          map_wdata = {1'b1, s_id};
          st_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // keep the destination degree read alive for the second write
        deg_raddr_b        = d_q;
        map_we             = new_dst_q;
        map_waddr          = cur_q.dst;
        map_wdata          = {1'b1, d_q};
        deg_we             = 1'b1;
        deg_waddr          = s_q;
        deg_wdata          = new_s;
        strobe_d           = 1'b1;
        res_d              = '0;
        res_d.kind         = KIND_FWD;
        res_d.first_word   = bswap32(32'(s_q));
        res_d.second_word  = bswap32(32'(d_q));
        res_d.vertex_count = vcount;
        st_d               = ST_FINISH;
      end
      ST_FINISH: begin
        deg_we             = ~cur_q.same;
        deg_waddr          = d_q;
        deg_wdata          = new_d;
        strobe_d           = 1'b1;
        res_d              = '0;
        res_d.kind         = KIND_REV;
        res_d.first_word   = bswap32(32'(d_q));
        res_d.second_word  = bswap32(32'(s_q));
        res_d.vertex_count = vcount;
        res_d.last         = 1'b1;
        st_d               = ST_IDLE;
      end
      ST_READOUT: begin
        strobe_d           = 1'b1;
        res_d              = '0;
        res_d.kind         = KIND_READ;
        res_d.degree_value = rd_ok_q ? deg_out : 32'd0;
        res_d.vertex_count = vcount;
        res_d.last         = 1'b1;
        st_d               = ST_IDLE;
      end
      default: st_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      next_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      clr_q    <= clr_d;
      next_q   <= next_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    s_q       <= s_d;
    d_q       <= d_d;
    s_old_q   <= s_old_d;
    d_old_q   <= d_old_d;
    new_dst_q <= new_dst_d;
    rd_ok_q   <= rd_ok_d;
    res_q     <= res_d;
  end

  // id map: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_a_q <= map_mem[head_i.src];
    map_rd_b_q <= map_mem[head_i.dst];
  end

  // degree store: stale entries at or above the fill count are masked to zero by the readout and update logic
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd_a_q <= deg_mem[deg_raddr_a];
    deg_rd_b_q <= deg_mem[deg_raddr_b];
  end

endmodule
`default_nettype wire
